### sv/lwkd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the longest-window block with a distinct-letter limit.
// Used by lwkd_ctrl, lwkd_dp and the top level longest_window_k_distinct. No dependencies.

package lwkd_pkg;

    // Default sizes of the string buffer and of the alphabet.
    localparam int MAX_LEN_DEF  = 1024;
    localparam int ALPHABET_DEF = 26;

    // Fixed port widths.
    localparam int LETTER_W = 5;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int LENGTH_W = 11;
    localparam int MAXD_W   = 5;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_MAX_DISTINCT = 1'b0;
    localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(1);

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_LONG = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // an input transaction is accepted this cycle
        logic evict;   // drop the letter at the window start
        logic settle;  // window is valid: record it if it is the longest
        logic emit;    // load the result register and clear the string state
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic took;        // the offered letter is in range and fits the buffer
        logic must_evict;  // the window holds too many distinct letters
        logic out_free;    // the result register can take a new result
    } t_dp_stat;

endpackage

### sv/longest_window_k_distinct.sv
`timescale 1ns / 1ps
// Top level of the longest-window block with a distinct-letter limit.
// Depends on lwkd_pkg, lwkd_ctrl and lwkd_dp; holds the configuration register.
//
//   Channel   Direction  Handshake                   Payload
//   -------   ---------  --------------------------  ------------------------------------
//   in        to block   i_in_valid / o_in_stall     i_letter, i_last
//   out       from block o_out_valid / i_out_stall   o_status, o_best_start, o_best_length
//   config    to block   APB psel/penable/pready     paddr, pwdata, prdata (max_distinct @ 0)
//
// A taken letter is stored, then letters are evicted from the window start one per
// cycle while too many distinct letters are held, and the window is settled; each
// letter is evicted at most once, bounded by the one-per-cycle buffer read. A letter
// flagged last then loads the result register once it is free. Out-of-range letters
// and letters that do not fit leave the window as is. Reset is synchronous; after it
// the block accepts input at once. A stalled result only holds up the next last letter.

module longest_window_k_distinct #(
    parameter int MAX_LEN  = lwkd_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = lwkd_pkg::ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lwkd_pkg::LETTER_W-1:0] i_letter,
    input  logic                          i_last,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lwkd_pkg::STATUS_W-1:0] o_status,
    output logic [lwkd_pkg::START_W-1:0]  o_best_start,
    output logic [lwkd_pkg::LENGTH_W-1:0] o_best_length,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lwkd_pkg::PADDR_W-1:0]  paddr,
    input  logic [lwkd_pkg::PDATA_W-1:0]  pwdata,
    output logic [lwkd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import lwkd_pkg::*;

    logic [MAXD_W-1:0] r_max_distinct;
    logic              reg_hit;
    t_dp_cmd           cmd;
    t_dp_stat          stat;

    // Register decode: paddr[2] selects the word; only word 0 holds a register.
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_MAX_DISTINCT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? PDATA_W'(r_max_distinct) : '0;

    // Distinct-letter limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distinct <= MAXD_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_distinct <= pwdata[MAXD_W-1:0];
        end
    end

    lwkd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lwkd_dp #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_letter       (i_letter),
        .i_max_distinct (r_max_distinct),
        .i_out_stall    (i_out_stall),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_best_start   (o_best_start),
        .o_best_length  (o_best_length)
    );

endmodule

### sv/lwkd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the longest-window block.
// Depends on lwkd_pkg for the command and status structs.

module lwkd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last,
    input  lwkd_pkg::t_dp_stat i_stat,
    output lwkd_pkg::t_dp_cmd  o_cmd,
    output logic               o_in_stall
);
    import lwkd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVICT = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_last     = i_last;
                    if (i_stat.took) begin
                        n_state = S_EVICT;
                    end else if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EVICT: begin
                if (i_stat.must_evict) begin
                    o_cmd.evict = 1'b1;
                end else begin
                    o_cmd.settle = 1'b1;
                    n_state      = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Input is held off whenever an item is still being worked on.
    assign o_in_stall = (r_state != S_IDLE);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // An eviction is only ever commanded while the datapath asks for one.
    a_evict_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.evict |-> i_stat.must_evict)
        else $error("eviction without an over-limit window");

    // A result is loaded only into a free result register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result loaded over a pending result");

    // After a taken letter the window is always settled before the next transaction.
    a_take_then_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_stat.took) |=> o_in_stall)
        else $error("input accepted before the window settled");

endmodule

### sv/lwkd_dp.sv
`timescale 1ns / 1ps
// Datapath for the longest-window block: letter buffer, per-letter counts, window
// bounds, best window and the result register. Depends on lwkd_pkg.

module lwkd_dp #(
    parameter int MAX_LEN  = lwkd_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = lwkd_pkg::ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lwkd_pkg::t_dp_cmd             i_cmd,
    input  logic [lwkd_pkg::LETTER_W-1:0] i_letter,
    input  logic [lwkd_pkg::MAXD_W-1:0]   i_max_distinct,
    input  logic                          i_out_stall,
    output lwkd_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    output logic [lwkd_pkg::STATUS_W-1:0] o_status,
    output logic [lwkd_pkg::START_W-1:0]  o_best_start,
    output logic [lwkd_pkg::LENGTH_W-1:0] o_best_length
);
    import lwkd_pkg::*;

    localparam int MW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;   // buffer address
    localparam int PW = $clog2(MAX_LEN + 1);                   // positions and counts
    localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1; // letter index
    localparam int DW = $clog2(ALPHABET + 1);                  // distinct totals

    // Letter buffer.
    logic [LETTER_W-1:0] r_text [MAX_LEN];
    logic [LETTER_W-1:0] r_rd_data;
    logic                r_byp;
    logic [LETTER_W-1:0] r_byp_data;
    logic [LETTER_W-1:0] old_letter;

    // Window state.
    logic [PW-1:0]       r_counts [ALPHABET];
    logic [ALPHABET-1:0] r_seen;
    logic [DW-1:0]       r_seen_total;
    logic [DW-1:0]       r_distinct;
    logic [PW-1:0]       r_window_start, n_window_start;
    logic [PW-1:0]       r_position;
    logic [PW-1:0]       r_best_begin;
    logic [PW-1:0]       r_best_span;
    logic                r_overflow;

    // Result register.
    logic                r_out_valid;
    t_status             r_status;
    logic [START_W-1:0]  r_out_start;
    logic [LENGTH_W-1:0] r_out_length;

    logic          in_range;
    logic          fits;
    logic          take_now;
    logic [AW-1:0] cnt_idx;
    logic [PW-1:0] cnt_cur;
    logic [PW-1:0] span;
    logic          wr_en;
    logic [MW-1:0] wr_addr;
    logic [MW-1:0] rd_addr;
    t_status       status_now;

    // Offered letter checks.
    assign in_range = (32'(i_letter) < ALPHABET);
    assign fits     = (32'(r_position) < MAX_LEN);
    assign take_now = i_cmd.take && in_range && fits;

    // One count is read per cycle: the new letter on a take, the oldest on an eviction.
    assign old_letter = r_byp ? r_byp_data : r_rd_data;
    assign cnt_idx    = i_cmd.evict ? AW'(old_letter) : AW'(i_letter);
    assign cnt_cur    = r_counts[cnt_idx];
    assign span       = r_position - r_window_start;

    // Status to the controller.
    assign o_stat.took       = in_range && fits;
    assign o_stat.must_evict = (int'(r_distinct) > int'(i_max_distinct)) &&
                               (r_window_start < r_position);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    // The buffer read always targets the next window start.
    always_comb begin
        n_window_start = r_window_start;
        if (i_cmd.emit) begin
            n_window_start = '0;
        end else if (i_cmd.evict) begin
            n_window_start = r_window_start + PW'(1);
        end
    end

    assign wr_en   = take_now;
    assign wr_addr = r_position[MW-1:0];
    assign rd_addr = n_window_start[MW-1:0];

    // Letter buffer with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_text[wr_addr] <= i_letter;
        end
        r_rd_data <= r_text[rd_addr];
    end

    // A read that collides with the write returns the new letter.
    always_ff @(posedge i_clk) begin
        r_byp      <= wr_en && (wr_addr == rd_addr);
        r_byp_data <= i_letter;
    end

    // Counts, distinct totals and window bounds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            for (int i = 0; i < ALPHABET; i++) begin
                r_counts[i] <= '0;
            end
            r_seen         <= '0;
            r_seen_total   <= '0;
            r_distinct     <= '0;
            r_window_start <= '0;
            r_position     <= '0;
            r_best_begin   <= '0;
            r_best_span    <= '0;
            r_overflow     <= 1'b0;
        end else begin
            if (i_cmd.take && in_range && !fits) begin
                r_overflow <= 1'b1;
            end
            if (take_now) begin
                r_position        <= r_position + PW'(1);
                r_counts[cnt_idx] <= cnt_cur + PW'(1);
                if (cnt_cur == '0) begin
                    r_distinct <= r_distinct + DW'(1);
                end
                if (!r_seen[cnt_idx]) begin
                    r_seen[cnt_idx] <= 1'b1;
                    r_seen_total    <= r_seen_total + DW'(1);
                end
            end
            if (i_cmd.evict) begin
                r_window_start <= n_window_start;
                if (cnt_cur != '0) begin
                    r_counts[cnt_idx] <= cnt_cur - PW'(1);
                    if (cnt_cur == PW'(1)) begin
                        r_distinct <= r_distinct - DW'(1);
                    end
                end
            end
            // Strictly longer windows only, so the earliest longest one stays.
            if (i_cmd.settle && (span > r_best_span)) begin
                r_best_span  <= span;
                r_best_begin <= r_window_start;
            end
        end
    end

    // Result status for the string that just ended.
    always_comb begin
        if (r_overflow) begin
            status_now = ST_LONG;
        end else if (int'(r_seen_total) < int'(i_max_distinct)) begin
            status_now = ST_FEW;
        end else begin
            status_now = ST_OK;
        end
    end

    // Result register: holds while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= status_now;
            if (status_now == ST_OK) begin
                r_out_start  <= START_W'(r_best_begin);
                r_out_length <= LENGTH_W'(r_best_span);
            end else begin
                r_out_start  <= '0;
                r_out_length <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_best_start  = r_out_start;
    assign o_best_length = r_out_length;

    // The window never runs past the written part of the buffer.
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window_start <= r_position)
        else $error("window start beyond the string end");

    // Letters in the window are a subset of the letters seen in the string.
    a_distinct_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_distinct <= r_seen_total)
        else $error("window holds more distinct letters than the string");

    // The best window fits inside the string so far.
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_span <= r_position)
        else $error("best window longer than the string");

endmodule
